// ----- design/khac_pkg.sv -----
// Package of the key hold action controller.
// Holds the command, configuration and result types, codes and reset values.
// Used by the front end, the back end and the top level; depends on nothing.
`default_nettype none

package khac_pkg;

    localparam int unsigned KEY_W = 16;
    localparam int unsigned CNT_W = 16;
    localparam int unsigned BLINK_W = 4;
    localparam int unsigned OFS_W = 3;

    // Item kinds, same codes as the operation field
    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    // Offsets of the special keys above the base keycode
    localparam logic [OFS_W-1:0] OFS_DEV1    = 3'd0;
    localparam logic [OFS_W-1:0] OFS_DEV3    = 3'd2;
    localparam logic [OFS_W-1:0] OFS_CLEAR   = 3'd3;
    localparam logic [OFS_W-1:0] OFS_WIRED   = 3'd4;
    localparam logic [OFS_W-1:0] OFS_FACTORY = 3'd5;
    localparam logic [OFS_W-1:0] OFS_MODE    = 3'd6;
    localparam logic [KEY_W-1:0] NUM_SPECIAL = 16'd7;

    // Alternate encoding: high byte of the raw keycode
    localparam logic [7:0] ALT_PAGE = 8'h7E;

    // Held key codes: 0 none, else offset + 1
    localparam logic [2:0] HELD_NONE    = 3'd0;
    localparam logic [2:0] HELD_DEV3    = 3'd3;
    localparam logic [2:0] HELD_FACTORY = 3'd6;

    // Key actions
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_CLEAR   = 3'd1;
    localparam logic [2:0] ACT_WIRED   = 3'd2;
    localparam logic [2:0] ACT_SWITCH  = 3'd3;
    localparam logic [2:0] ACT_PAIR    = 3'd4;
    localparam logic [2:0] ACT_FACTORY = 3'd5;

    // Mode changes
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_ENTER = 2'd1;
    localparam logic [1:0] MODE_LEAVE = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_KEY_BASE   = 3'd0;
    localparam logic [2:0] REG_PAIR_HOLD  = 3'd1;
    localparam logic [2:0] REG_RESET_HOLD = 3'd2;
    localparam logic [2:0] REG_MODE_HOLD  = 3'd3;
    localparam logic [2:0] REG_FLASH_ON   = 3'd4;
    localparam logic [2:0] REG_FLASH_OFF  = 3'd5;
    localparam logic [2:0] REG_FLASH_BLNK = 3'd6;

    // Register reset values
    localparam logic [KEY_W-1:0]   RST_KEY_BASE   = 16'd32320;
    localparam logic [CNT_W-1:0]   RST_PAIR_HOLD  = 16'd3000;
    localparam logic [CNT_W-1:0]   RST_RESET_HOLD = 16'd5000;
    localparam logic [CNT_W-1:0]   RST_MODE_HOLD  = 16'd3000;
    localparam logic [CNT_W-1:0]   RST_FLASH_ON   = 16'd1000;
    localparam logic [CNT_W-1:0]   RST_FLASH_OFF  = 16'd500;
    localparam logic [BLINK_W-1:0] RST_FLASH_BLNK = 4'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]       kind;
        logic             special;
        logic [OFS_W-1:0] ofs;
    } t_cmd;

    typedef struct packed {
        logic [KEY_W-1:0]   key_base;
        logic [CNT_W-1:0]   pair_hold;
        logic [CNT_W-1:0]   reset_hold;
        logic [CNT_W-1:0]   mode_hold;
        logic [CNT_W-1:0]   flash_on;
        logic [CNT_W-1:0]   flash_off;
        logic [BLINK_W-1:0] flash_blinks;
    } t_cfg;

    typedef struct packed {
        logic       flash_led;
        logic       lock_active;
        logic [1:0] mode_change;
        logic [1:0] device_index;
        logic [2:0] key_action;
        logic       activity;
        logic       pass_through;
    } t_result;

endpackage

`default_nettype wire

// ----- design/khac_front.sv -----
// Front end: takes input requests and classifies each key into a command.
// Depends on khac_pkg.
`default_nettype none

module khac_front (
    input  wire logic                    [1:0] i_operation,
    input  wire logic     [khac_pkg::KEY_W-1:0] i_key_code,
    input  wire logic     [khac_pkg::KEY_W-1:0] i_key_base,
    output khac_pkg::t_cmd                     o_cmd
);
    import khac_pkg::*;

    logic [KEY_W-1:0] w_diff;
    logic             w_alt;

    always_comb begin
        w_alt  = (i_key_code[15:8] == ALT_PAGE) && ({8'd0, i_key_code[7:0]} < NUM_SPECIAL);
        w_diff = i_key_code - i_key_base;
        unique case (i_operation)
            KIND_PRESS:   o_cmd.kind = KIND_PRESS;
            KIND_RELEASE: o_cmd.kind = KIND_RELEASE;
            KIND_TICK:    o_cmd.kind = KIND_TICK;
            default:      o_cmd.kind = KIND_NONE;
        endcase
        // Alternate encoding maps straight to its offset
        if (w_alt) begin
            o_cmd.special = 1'b1;
            o_cmd.ofs     = i_key_code[OFS_W-1:0];
        end else begin
            o_cmd.special = (w_diff < NUM_SPECIAL);
            o_cmd.ofs     = w_diff[OFS_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- design/khac_fifo.sv -----
// Short command queue between the front end and the back end.
// Register based; depends on nothing.
`default_nettype none

module khac_fifo #(
    parameter int unsigned WIDTH = 6,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic      [WIDTH-1:0] o_data
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/khac_back.sv -----
// Back end: carries out queued commands on the hold, lock and flash state
// and holds the result register. Depends on khac_pkg.
`default_nettype none

module khac_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire khac_pkg::t_cfg i_cfg,
    input  wire logic           i_cmd_valid,
    input  wire khac_pkg::t_cmd i_cmd,
    output logic                o_cmd_pop,
    output logic                o_res_valid,
    input  wire logic           i_res_ready,
    output khac_pkg::t_result   o_res
);
    import khac_pkg::*;

    logic [2:0]         r_held_key,    n_held_key;
    logic [CNT_W-1:0]   r_hold_count,  n_hold_count;
    logic               r_hold_fired,  n_hold_fired;
    logic               r_lock_mode,   n_lock_mode;
    logic               r_mode_down,   n_mode_down;
    logic [CNT_W-1:0]   r_mode_count,  n_mode_count;
    logic               r_mode_fired,  n_mode_fired;
    logic [BLINK_W-1:0] r_blinks_left, n_blinks_left;
    logic               r_flash_lit,   n_flash_lit;
    logic [CNT_W-1:0]   r_flash_timer, n_flash_timer;
    logic               r_res_valid;
    t_result            r_res,         n_res;

    logic             w_start;
    logic             w_started;
    logic [CNT_W-1:0] w_t;
    logic [CNT_W-1:0] w_limit;

    assign o_cmd_pop   = i_cmd_valid && (!r_res_valid || i_res_ready);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        n_held_key    = r_held_key;
        n_hold_count  = r_hold_count;
        n_hold_fired  = r_hold_fired;
        n_lock_mode   = r_lock_mode;
        n_mode_down   = r_mode_down;
        n_mode_count  = r_mode_count;
        n_mode_fired  = r_mode_fired;
        n_blinks_left = r_blinks_left;
        n_flash_lit   = r_flash_lit;
        n_flash_timer = r_flash_timer;
        n_res         = '0;
        w_start       = 1'b0;
        w_started     = 1'b0;
        w_t           = '0;
        w_limit       = (r_held_key == HELD_FACTORY) ? i_cfg.reset_hold : i_cfg.pair_hold;

        unique case (i_cmd.kind)
            KIND_PRESS, KIND_RELEASE: begin
                n_res.activity = (i_cmd.kind == KIND_PRESS);
                priority if (r_lock_mode && !(i_cmd.special && i_cmd.ofs == OFS_MODE)) begin
                    // Swallow everything but the mode key while locked
                    n_res.pass_through = 1'b0;
                end else if (!i_cmd.special) begin
                    n_res.pass_through = 1'b1;
                end else if (i_cmd.kind == KIND_PRESS) begin
                    priority if (i_cmd.ofs == OFS_CLEAR) begin
                        n_res.key_action = ACT_CLEAR;
                    end else if (i_cmd.ofs == OFS_WIRED) begin
                        n_res.key_action = ACT_WIRED;
                    end else if (i_cmd.ofs == OFS_MODE) begin
                        n_mode_down  = 1'b1;
                        n_mode_count = '0;
                        n_mode_fired = 1'b0;
                    end else begin
                        n_held_key   = i_cmd.ofs + 3'd1;
                        n_hold_count = '0;
                        n_hold_fired = 1'b0;
                    end
                end else begin
                    if (i_cmd.ofs == OFS_MODE) begin
                        n_mode_down = 1'b0;
                        w_start     = !r_mode_fired && (r_blinks_left == '0);
                    end else if (i_cmd.ofs != OFS_CLEAR && i_cmd.ofs != OFS_WIRED
                                 && r_held_key == i_cmd.ofs + 3'd1) begin
                        if (!r_hold_fired && i_cmd.ofs <= OFS_DEV3) begin
                            n_res.key_action   = ACT_SWITCH;
                            n_res.device_index = i_cmd.ofs[1:0] + 2'd1;
                        end
                        n_held_key   = HELD_NONE;
                        n_hold_count = '0;
                        n_hold_fired = 1'b0;
                    end
                end
            end
            KIND_TICK: begin
                if (r_held_key != HELD_NONE && !r_hold_fired) begin
                    n_hold_count = (r_hold_count != CNT_MAX) ? r_hold_count + 1'b1 : r_hold_count;
                    if (n_hold_count >= w_limit) begin
                        if (r_held_key == HELD_FACTORY) begin
                            n_res.key_action = ACT_FACTORY;
                        end else if (r_held_key <= HELD_DEV3) begin
                            n_res.key_action   = ACT_PAIR;
                            n_res.device_index = r_held_key[1:0];
                        end
                        n_hold_fired = 1'b1;
                    end
                end
                if (r_mode_down && !r_mode_fired) begin
                    n_mode_count = (r_mode_count != CNT_MAX) ? r_mode_count + 1'b1 : r_mode_count;
                    if (n_mode_count >= i_cfg.mode_hold) begin
                        n_lock_mode       = !r_lock_mode;
                        n_res.mode_change = r_lock_mode ? MODE_LEAVE : MODE_ENTER;
                        w_start           = 1'b1;
                        w_started         = 1'b1;
                        n_mode_fired      = 1'b1;
                    end
                end
                // Advance the blink sequencer unless it just restarted
                if (!w_started && r_blinks_left != '0) begin
                    w_t = (r_flash_timer != '0) ? r_flash_timer - 1'b1 : r_flash_timer;
                    n_flash_timer = w_t;
                    if (w_t == '0) begin
                        if (r_flash_lit) begin
                            n_flash_lit   = 1'b0;
                            n_flash_timer = i_cfg.flash_off;
                        end else begin
                            n_blinks_left = r_blinks_left - 1'b1;
                            if (n_blinks_left != '0) begin
                                n_flash_lit   = 1'b1;
                                n_flash_timer = i_cfg.flash_on;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        if (w_start) begin
            n_blinks_left = i_cfg.flash_blinks;
            n_flash_lit   = (i_cfg.flash_blinks != '0);
            n_flash_timer = i_cfg.flash_on;
        end

        n_res.lock_active = n_lock_mode;
        n_res.flash_led   = n_flash_lit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_key    <= HELD_NONE;
            r_hold_count  <= '0;
            r_hold_fired  <= 1'b0;
            r_lock_mode   <= 1'b0;
            r_mode_down   <= 1'b0;
            r_mode_count  <= '0;
            r_mode_fired  <= 1'b0;
            r_blinks_left <= '0;
            r_flash_lit   <= 1'b0;
            r_flash_timer <= '0;
            r_res_valid   <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_held_key    <= n_held_key;
                r_hold_count  <= n_hold_count;
                r_hold_fired  <= n_hold_fired;
                r_lock_mode   <= n_lock_mode;
                r_mode_down   <= n_mode_down;
                r_mode_count  <= n_mode_count;
                r_mode_fired  <= n_mode_fired;
                r_blinks_left <= n_blinks_left;
                r_flash_lit   <= n_flash_lit;
                r_flash_timer <= n_flash_timer;
                r_res_valid   <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

// ----- design/key_hold_action_controller_unit.sv -----
// Top level of the key hold action controller: configuration registers,
// front end, command queue and back end. Depends on khac_pkg, khac_front,
// khac_fifo and khac_back.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: operation[1:0]; tdata: key_code[15:0]
//  m_axis    out        tdata: pass_through, activity, key_action[2:0],
//                       device_index[1:0], mode_change[1:0], lock_active,
//                       flash_led, zero pad to 16 bits
//  apb       in/out     seven registers at byte addresses 0x00..0x18
//
// One request a cycle sustained while m_axis takes the results. A request is
// classified as it is taken and pushed into the command queue; the back end
// pops it once the result register is free and, with that pop, updates all
// hold, lock and flash state and registers the result. The state update in
// the back end sets the rate. s_axis_tready drops only when the queue is full;
// a stalled m_axis holds the result register and backs up the queue.
// Reset is synchronous: it empties the queue, clears all state and loads
// the register reset values.
`default_nettype none

module key_hold_action_controller_unit #(
    parameter int unsigned FIFO_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input requests
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // key_code[15:0]
    input  wire logic [1:0]  s_axis_tuser,   // operation[1:0]
    // Results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // pass_through, activity, key_action[2:0],
                                             // device_index[1:0], mode_change[1:0],
                                             // lock_active, flash_led, pad
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import khac_pkg::*;

    localparam int unsigned CMD_W = $bits(t_cmd);
    localparam int unsigned RES_W = $bits(t_result);

    t_cfg             r_cfg;
    t_cmd             w_front_cmd;
    logic [CMD_W-1:0] w_q_data;
    t_cmd             w_back_cmd;
    logic             w_q_full, w_q_empty, w_pop, w_push;
    t_result          w_res;
    logic             w_cfg_wr;
    logic [2:0]       w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = paddr[4:2];

    // Register file; writes to addresses past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_base     <= RST_KEY_BASE;
            r_cfg.pair_hold    <= RST_PAIR_HOLD;
            r_cfg.reset_hold   <= RST_RESET_HOLD;
            r_cfg.mode_hold    <= RST_MODE_HOLD;
            r_cfg.flash_on     <= RST_FLASH_ON;
            r_cfg.flash_off    <= RST_FLASH_OFF;
            r_cfg.flash_blinks <= RST_FLASH_BLNK;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_KEY_BASE:   r_cfg.key_base     <= pwdata[KEY_W-1:0];
                REG_PAIR_HOLD:  r_cfg.pair_hold    <= pwdata[CNT_W-1:0];
                REG_RESET_HOLD: r_cfg.reset_hold   <= pwdata[CNT_W-1:0];
                REG_MODE_HOLD:  r_cfg.mode_hold    <= pwdata[CNT_W-1:0];
                REG_FLASH_ON:   r_cfg.flash_on     <= pwdata[CNT_W-1:0];
                REG_FLASH_OFF:  r_cfg.flash_off    <= pwdata[CNT_W-1:0];
                REG_FLASH_BLNK: r_cfg.flash_blinks <= pwdata[BLINK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (w_reg_idx)
            REG_KEY_BASE:   prdata = {16'd0, r_cfg.key_base};
            REG_PAIR_HOLD:  prdata = {16'd0, r_cfg.pair_hold};
            REG_RESET_HOLD: prdata = {16'd0, r_cfg.reset_hold};
            REG_MODE_HOLD:  prdata = {16'd0, r_cfg.mode_hold};
            REG_FLASH_ON:   prdata = {16'd0, r_cfg.flash_on};
            REG_FLASH_OFF:  prdata = {16'd0, r_cfg.flash_off};
            REG_FLASH_BLNK: prdata = {28'd0, r_cfg.flash_blinks};
            default:        prdata = '0;
        endcase
    end

    // Take a request whenever the queue has room
    assign s_axis_tready = !w_q_full;
    assign w_push        = s_axis_tvalid && !w_q_full;

    khac_front u_front (
        .i_operation (s_axis_tuser),
        .i_key_code  (s_axis_tdata),
        .i_key_base  (r_cfg.key_base),
        .o_cmd       (w_front_cmd)
    );

    khac_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q_data)
    );

    assign w_back_cmd = t_cmd'(w_q_data);

    khac_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (!w_q_empty),
        .i_cmd       (w_back_cmd),
        .o_cmd_pop   (w_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res)
    );

    // Pack the result from the lowest bit up, zero padded to two bytes
    assign m_axis_tdata = {(16 - RES_W)'(0), w_res};

endmodule

`default_nettype wire

// ----- bench/key_hold_action_controller_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for key_hold_action_controller_unit: random stream
// traffic with stalls, APB register phases and an in-bench prediction of
// every result. Depends on khac_pkg and the controller RTL only.

module key_hold_action_controller_unit_test;

    import khac_pkg::*;

    // ------------------------------------------------------------------
    // Action ledger: mirrors the controller state, predicts the result of
    // every accepted request and checks the results in order.
    // ------------------------------------------------------------------
    class key_action_ledger;
        logic [KEY_W-1:0]   key_base;
        logic [CNT_W-1:0]   pair_hold, reset_hold, mode_hold, flash_on, flash_off;
        logic [BLINK_W-1:0] flash_blinks;

        logic [2:0]         held_key;
        logic [CNT_W-1:0]   hold_count, mode_count, flash_timer;
        bit                 hold_fired, lock_mode, mode_down, mode_fired, flash_lit;
        logic [BLINK_W-1:0] blinks_left;

        t_result expected_actions[$];
        int      errors;

        function new();
            key_base     = RST_KEY_BASE;
            pair_hold    = RST_PAIR_HOLD;
            reset_hold   = RST_RESET_HOLD;
            mode_hold    = RST_MODE_HOLD;
            flash_on     = RST_FLASH_ON;
            flash_off    = RST_FLASH_OFF;
            flash_blinks = RST_FLASH_BLNK;
            held_key     = HELD_NONE;
            hold_count   = '0;
            mode_count   = '0;
            flash_timer  = '0;
            hold_fired   = 0;
            lock_mode    = 0;
            mode_down    = 0;
            mode_fired   = 0;
            flash_lit    = 0;
            blinks_left  = '0;
            errors       = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_KEY_BASE:   key_base     = data[KEY_W-1:0];
                REG_PAIR_HOLD:  pair_hold    = data[CNT_W-1:0];
                REG_RESET_HOLD: reset_hold   = data[CNT_W-1:0];
                REG_MODE_HOLD:  mode_hold    = data[CNT_W-1:0];
                REG_FLASH_ON:   flash_on     = data[CNT_W-1:0];
                REG_FLASH_OFF:  flash_off    = data[CNT_W-1:0];
                REG_FLASH_BLNK: flash_blinks = data[BLINK_W-1:0];
                default: ;
            endcase
        endfunction

        function void start_flash();
            blinks_left = flash_blinks;
            flash_lit   = (blinks_left != 0);
            flash_timer = flash_on;
        endfunction

        function void advance_flash();
            if (blinks_left == 0) return;
            if (flash_timer != 0) flash_timer--;
            if (flash_timer != 0) return;
            if (flash_lit) begin
                flash_lit   = 0;
                flash_timer = flash_off;
            end else begin
                blinks_left--;
                if (blinks_left != 0) begin
                    flash_lit   = 1;
                    flash_timer = flash_on;
                end
            end
        endfunction

        function t_result predict_action(logic [1:0] op, logic [KEY_W-1:0] key);
            t_result          r;
            logic [KEY_W-1:0] code;
            logic [KEY_W-1:0] ofs;
            logic [CNT_W-1:0] limit;
            bit               started;
            r       = '0;
            started = 0;
            if (op == KIND_PRESS || op == KIND_RELEASE) begin
                if (op == KIND_PRESS) r.activity = 1'b1;
                code = key;
                if (key[15:8] == ALT_PAGE && key[7:0] < 8'd7)
                    code = key_base + {8'h00, key[7:0]};
                ofs = code - key_base;
                if (lock_mode && ofs != OFS_MODE) begin
                    // swallowed while locked
                end else if (ofs >= NUM_SPECIAL) begin
                    r.pass_through = 1'b1;
                end else if (op == KIND_PRESS) begin
                    if (ofs == OFS_CLEAR) begin
                        r.key_action = ACT_CLEAR;
                    end else if (ofs == OFS_WIRED) begin
                        r.key_action = ACT_WIRED;
                    end else if (ofs == OFS_MODE) begin
                        mode_down  = 1;
                        mode_count = '0;
                        mode_fired = 0;
                    end else begin
                        held_key   = ofs[2:0] + 3'd1;
                        hold_count = '0;
                        hold_fired = 0;
                    end
                end else begin
                    if (ofs == OFS_MODE) begin
                        mode_down = 0;
                        if (!mode_fired && blinks_left == 0) start_flash();
                    end else if (ofs != OFS_CLEAR && ofs != OFS_WIRED &&
                                 held_key == ofs[2:0] + 3'd1) begin
                        if (!hold_fired && ofs <= OFS_DEV3) begin
                            r.key_action   = ACT_SWITCH;
                            r.device_index = ofs[1:0] + 2'd1;
                        end
                        held_key   = HELD_NONE;
                        hold_count = '0;
                        hold_fired = 0;
                    end
                end
            end else if (op == KIND_TICK) begin
                if (held_key != HELD_NONE && !hold_fired) begin
                    limit = (held_key == HELD_FACTORY) ? reset_hold : pair_hold;
                    if (hold_count != CNT_MAX) hold_count++;
                    if (hold_count >= limit) begin
                        if (held_key == HELD_FACTORY) begin
                            r.key_action = ACT_FACTORY;
                        end else if (held_key <= HELD_DEV3) begin
                            r.key_action   = ACT_PAIR;
                            r.device_index = held_key[1:0];
                        end
                        hold_fired = 1;
                    end
                end
                if (mode_down && !mode_fired) begin
                    if (mode_count != CNT_MAX) mode_count++;
                    if (mode_count >= mode_hold) begin
                        lock_mode     = !lock_mode;
                        r.mode_change = lock_mode ? MODE_ENTER : MODE_LEAVE;
                        start_flash();
                        started    = 1;
                        mode_fired = 1;
                    end
                end
                if (!started) advance_flash();
            end
            r.lock_active = lock_mode;
            r.flash_led   = flash_lit;
            return r;
        endfunction

        function void note_request(logic [1:0] op, logic [KEY_W-1:0] key);
            expected_actions.push_back(predict_action(op, key));
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_action(t_result got);
            t_result want;
            if (expected_actions.size() == 0) begin
                $error("result 0x%0h arrived with no request pending", got);
                errors++;
                return;
            end
            want = expected_actions.pop_front();
            compare_field("pass_through", want.pass_through, got.pass_through);
            compare_field("activity",     want.activity,     got.activity);
            compare_field("key_action",   want.key_action,   got.key_action);
            compare_field("device_index", want.device_index, got.device_index);
            compare_field("mode_change",  want.mode_change,  got.mode_change);
            compare_field("lock_active",  want.lock_active,  got.lock_active);
            compare_field("flash_led",    want.flash_led,    got.flash_led);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // key_code[15:0]
    logic [1:0]  s_axis_tuser;   // operation[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // pass_through, activity, key_action[2:0],
                                 // device_index[1:0], mode_change[1:0],
                                 // lock_active, flash_led, pad
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    key_hold_action_controller_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    key_action_ledger board;
    int  requests_sent;
    bit  sender_burst;   // when set, offer requests back to back

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or stalls forever.
    initial begin
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------

    // One APB write: setup phase, access phase, then an idle phase so the
    // next write never touches psel twice in the same step. Upper data bits
    // are random; the block must keep only the register's own width.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        logic [31:0] data;
        data = {16'($urandom_range(0, 65535)), value};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);   // register is written at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_register(idx, data);
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] base, input logic [15:0] pair,
                             input logic [15:0] rst_hold, input logic [15:0] mode,
                             input logic [15:0] on_t, input logic [15:0] off_t,
                             input logic [3:0] blinks);
        write_reg(REG_KEY_BASE,   base);
        write_reg(REG_PAIR_HOLD,  pair);
        write_reg(REG_RESET_HOLD, rst_hold);
        write_reg(REG_MODE_HOLD,  mode);
        write_reg(REG_FLASH_ON,   on_t);
        write_reg(REG_FLASH_OFF,  off_t);
        write_reg(REG_FLASH_BLNK, {12'h000, blinks});
    endtask

    // Offer one request after a random gap (none in burst mode) and hold it
    // until the block takes it; the ledger predicts at the accepting edge.
    task automatic send_request(input logic [1:0] op, input logic [15:0] key);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= key;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        board.note_request(op, key);
        requests_sent++;
    endtask

    // Keycode of a special key, in the plain or the alternate encoding.
    function automatic logic [15:0] special_code(input logic [2:0] ofs);
        if ($urandom_range(0, 1) == 0)
            return board.key_base + {13'd0, ofs};
        return {ALT_PAGE, 5'd0, ofs};
    endfunction

    // Hand-picked opening traffic; assumes base 0xFFFC so the special range
    // wraps through zero: devices FFFC..FFFE, clear FFFF, wired 0000,
    // factory 0001, mode 0002. Pair after 2 ticks, reset after 3, mode 2.
    task automatic run_directed();
        send_request(KIND_PRESS,   16'h0000 + 16'h1234); // ordinary key passes
        send_request(KIND_RELEASE, 16'h8000);
        send_request(KIND_NONE,    16'hFFFF);            // unused op is ignored
        send_request(KIND_PRESS,   16'h7E01);            // device 2, alternate form
        send_request(KIND_TICK,    16'h0000);
        send_request(KIND_TICK,    16'hFFFF);            // long press: pair 2
        send_request(KIND_RELEASE, 16'h7E01);            // no switch after pair
        send_request(KIND_PRESS,   16'hFFFC);            // short press: switch 1
        send_request(KIND_RELEASE, 16'hFFFC);
        send_request(KIND_PRESS,   16'hFFFF);            // clear acts on press
        send_request(KIND_PRESS,   16'h0000);            // wired acts on press
        send_request(KIND_RELEASE, 16'h0000);
        send_request(KIND_RELEASE, 16'h0001);            // stray factory release
        send_request(KIND_PRESS,   16'h0001);
        repeat (3) send_request(KIND_TICK, 16'h5A5A);    // factory reset fires
        send_request(KIND_RELEASE, 16'h0001);
        send_request(KIND_RELEASE, 16'h7E06);            // stray mode release: flash
        send_request(KIND_PRESS,   16'h0002);
        repeat (2) send_request(KIND_TICK, 16'h0000);    // lock entered
        send_request(KIND_PRESS,   16'h7E07);            // not alternate; swallowed
        send_request(KIND_RELEASE, 16'hFFFE);            // swallowed in lock
        send_request(KIND_RELEASE, 16'h0002);
    endtask

    // Mostly well-formed press / hold / release sequences with random keys
    // and hold lengths around the thresholds; the rest is tick runs for the
    // flash, stray special keys and raw noise.
    task automatic run_random(input int budget);
        int          stop_at, pick, ticks, limit;
        logic [2:0]  ofs;
        logic [15:0] code;
        stop_at = requests_sent + budget;
        while (requests_sent < stop_at) begin
            if ($urandom_range(0, 31) == 0) sender_burst = !sender_burst;
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                ofs   = 3'($urandom_range(0, 6));
                limit = (ofs == OFS_MODE)    ? board.mode_hold :
                        (ofs == OFS_FACTORY) ? board.reset_hold : board.pair_hold;
                if (limit > 24) limit = 24;
                ticks = $urandom_range(0, limit + 2);
                send_request(KIND_PRESS, special_code(ofs));
                repeat (ticks) begin
                    if ($urandom_range(0, 7) == 0)
                        send_request(2'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
                    else
                        send_request(KIND_TICK, 16'($urandom_range(0, 65535)));
                end
                // now and then release the wrong key to leave a hold running
                if ($urandom_range(0, 7) == 0) ofs = 3'($urandom_range(0, 6));
                send_request(KIND_RELEASE, special_code(ofs));
            end else if (pick < 8) begin
                repeat ($urandom_range(1, 40))
                    send_request(KIND_TICK, 16'($urandom_range(0, 65535)));
            end else if (pick == 8) begin
                send_request(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
            end else begin
                code = special_code(3'($urandom_range(0, 6)));
                send_request(2'($urandom_range(0, 1)), code);
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (board.expected_actions.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, bursts with tready held high, and one
    // long hold-off that lets the queue fill and stall the input side.
    // ------------------------------------------------------------------
    initial begin
        int results_seen;
        int stall;
        bit drain_fast;
        results_seen  = 0;
        drain_fast    = 0;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0) drain_fast = !drain_fast;
            stall = drain_fast ? 0 : $urandom_range(0, 16);
            if (results_seen == 150) stall = 400;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            board.check_action(t_result'(m_axis_tdata[10:0]));
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, then one register setting per phase with
    // directed traffic in the first and random traffic in all of them.
    // ------------------------------------------------------------------
    initial begin
        board         = new();
        requests_sent = 0;
        sender_burst  = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // wrapping special range, short holds, short flash
        configure(16'hFFFC, 16'd2, 16'd3, 16'd2, 16'd1, 16'd1, 4'd2);
        run_directed();
        run_random(380);
        wait_idle();

        // zero thresholds and phases: holds fire on the first tick, no flash
        configure(16'h0000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 4'd0);
        run_random(400);
        wait_idle();

        // top of the keycode range, longest blink sequence
        configure(16'hFFFF, 16'd5, 16'd8, 16'd4, 16'd3, 16'd2, 4'd15);
        run_random(400);
        wait_idle();

        // largest thresholds: holds never complete here, flash stays lit
        configure(16'($urandom_range(0, 65535)), 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  16'hFFFF, 16'hFFFF, 4'd1);
        run_random(400);
        wait_idle();

        // random small setting around the reset base
        configure(RST_KEY_BASE, 16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                  16'($urandom_range(1, 12)), 16'($urandom_range(1, 6)),
                  16'($urandom_range(1, 6)), 4'($urandom_range(1, 15)));
        run_random(400);

        // drain, then give the pipeline time to show any stray result
        while (board.expected_actions.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
